[rtl/bbr_pkg.sv]
// Shared types and constants for the horizontal box blur row stream.
// Holds widths, the reciprocal table, the sequencer state type and control structs.
// No dependencies; compile first.
package bbr_pkg;

	// Kernel and pixel geometry
	localparam int MAX_RADIUS = 63;
	localparam int RADIUS_W   = 6;
	localparam int NUM_LANES  = 4;
	localparam int CH_W       = 8;
	localparam int PIX_W      = NUM_LANES * CH_W;

	// Arithmetic widths: 127 * 255 fits in 15 bits, reciprocal is Q24 in 25 bits
	localparam int SUM_W   = 15;
	localparam int RECIP_W = 25;
	localparam int FRAC_W  = 24;
	localparam int PROD_W  = SUM_W + RECIP_W;

	// Window memory and pixel count (count saturates at 2*MAX_RADIUS+1)
	localparam int COUNT_W   = RADIUS_W + 1;
	localparam int WIN_AW    = COUNT_W;
	localparam int WIN_DEPTH = 1 << WIN_AW;
	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(2 * MAX_RADIUS + 1);

	// floor(2^24 / (2r+1)) for r = 0..63, entry r at index r
	localparam logic [RECIP_W-1:0] ONE_Q24 = RECIP_W'(1) << FRAC_W;
	localparam logic [0:63][RECIP_W-1:0] RECIP_TAB = {
		RECIP_W'(ONE_Q24/1),   RECIP_W'(ONE_Q24/3),   RECIP_W'(ONE_Q24/5),
		RECIP_W'(ONE_Q24/7),   RECIP_W'(ONE_Q24/9),   RECIP_W'(ONE_Q24/11),
		RECIP_W'(ONE_Q24/13),  RECIP_W'(ONE_Q24/15),  RECIP_W'(ONE_Q24/17),
		RECIP_W'(ONE_Q24/19),  RECIP_W'(ONE_Q24/21),  RECIP_W'(ONE_Q24/23),
		RECIP_W'(ONE_Q24/25),  RECIP_W'(ONE_Q24/27),  RECIP_W'(ONE_Q24/29),
		RECIP_W'(ONE_Q24/31),  RECIP_W'(ONE_Q24/33),  RECIP_W'(ONE_Q24/35),
		RECIP_W'(ONE_Q24/37),  RECIP_W'(ONE_Q24/39),  RECIP_W'(ONE_Q24/41),
		RECIP_W'(ONE_Q24/43),  RECIP_W'(ONE_Q24/45),  RECIP_W'(ONE_Q24/47),
		RECIP_W'(ONE_Q24/49),  RECIP_W'(ONE_Q24/51),  RECIP_W'(ONE_Q24/53),
		RECIP_W'(ONE_Q24/55),  RECIP_W'(ONE_Q24/57),  RECIP_W'(ONE_Q24/59),
		RECIP_W'(ONE_Q24/61),  RECIP_W'(ONE_Q24/63),  RECIP_W'(ONE_Q24/65),
		RECIP_W'(ONE_Q24/67),  RECIP_W'(ONE_Q24/69),  RECIP_W'(ONE_Q24/71),
		RECIP_W'(ONE_Q24/73),  RECIP_W'(ONE_Q24/75),  RECIP_W'(ONE_Q24/77),
		RECIP_W'(ONE_Q24/79),  RECIP_W'(ONE_Q24/81),  RECIP_W'(ONE_Q24/83),
		RECIP_W'(ONE_Q24/85),  RECIP_W'(ONE_Q24/87),  RECIP_W'(ONE_Q24/89),
		RECIP_W'(ONE_Q24/91),  RECIP_W'(ONE_Q24/93),  RECIP_W'(ONE_Q24/95),
		RECIP_W'(ONE_Q24/97),  RECIP_W'(ONE_Q24/99),  RECIP_W'(ONE_Q24/101),
		RECIP_W'(ONE_Q24/103), RECIP_W'(ONE_Q24/105), RECIP_W'(ONE_Q24/107),
		RECIP_W'(ONE_Q24/109), RECIP_W'(ONE_Q24/111), RECIP_W'(ONE_Q24/113),
		RECIP_W'(ONE_Q24/115), RECIP_W'(ONE_Q24/117), RECIP_W'(ONE_Q24/119),
		RECIP_W'(ONE_Q24/121), RECIP_W'(ONE_Q24/123), RECIP_W'(ONE_Q24/125),
		RECIP_W'(ONE_Q24/127)
	};
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_MUL,
		ST_PUSH
	} bbr_state_t;

	// Controls shared by all channel lanes
	typedef struct packed {
		logic clear;
		logic acc_en;
		logic mul_en;
	} lane_ctl_t;

	// Controls for the output merge register
	typedef struct packed {
		logic load;
		logic row_end;
		logic run_final;
	} merge_ctl_t;

endpackage

[rtl/bbr_window.sv]
// Circular pixel window: 128 x 32-bit memory, one write and one registered read per cycle.
// The write pointer marks the newest pixel. Depends on bbr_pkg.
module bbr_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [bbr_pkg::PIX_W-1:0]  wdata,
	input  logic [bbr_pkg::WIN_AW-1:0] raddr,
	output logic [bbr_pkg::PIX_W-1:0]  rdata,
	output logic [bbr_pkg::WIN_AW-1:0] newest
);
	import bbr_pkg::*;

	logic [PIX_W-1:0]  mem [WIN_DEPTH];
	logic [WIN_AW-1:0] wp_q;
	logic [PIX_W-1:0]  rdata_q;

	// write pointer advances on every stored pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (we) begin
			wp_q <= wp_q + WIN_AW'(1);
		end
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wp_q + WIN_AW'(1)] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata  = rdata_q;
	assign newest = wp_q;

endmodule

[rtl/bbr_lane.sv]
// One channel lane: accumulates window bytes, then scales by the Q24 reciprocal.
// Result is (sum * recip) >> 24, low byte. Depends on bbr_pkg.
module bbr_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bbr_pkg::lane_ctl_t          ctl,
	input  logic [bbr_pkg::CH_W-1:0]    pix,
	input  logic [bbr_pkg::RECIP_W-1:0] recip,
	output logic [bbr_pkg::CH_W-1:0]    res
);
	import bbr_pkg::*;

	logic [SUM_W-1:0]  acc_q;
	logic [CH_W-1:0]   res_q;
	logic [PROD_W-1:0] prod;

	// window sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + SUM_W'(pix);
		end
	end

	// scale: one 15x25 multiply, registered
	assign prod = PROD_W'(acc_q) * PROD_W'(recip);

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			res_q <= prod[FRAC_W +: CH_W];
		end
	end

	assign res = res_q;

endmodule

[rtl/bbr_merge.sv]
// Output merge: packs the four lane bytes into one pixel and holds it for the consumer.
// Frees as soon as the held item is taken. Depends on bbr_pkg.
module bbr_merge (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  bbr_pkg::merge_ctl_t                         ctl,
	input  logic [bbr_pkg::NUM_LANES-1:0][bbr_pkg::CH_W-1:0] lane_res,
	input  logic                                        out_stall,
	output logic                                        out_valid,
	output logic [bbr_pkg::PIX_W-1:0]                   blurred_pixel,
	output logic                                        row_end_out,
	output logic                                        run_final,
	output logic                                        free
);
	import bbr_pkg::*;

	logic             valid_q;
	logic [PIX_W-1:0] pix_q;
	logic             row_end_q;
	logic             final_q;

	assign free = !valid_q || !out_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			pix_q     <= lane_res;
			row_end_q <= ctl.row_end;
			final_q   <= ctl.run_final;
		end
	end

	assign out_valid     = valid_q;
	assign blurred_pixel = pix_q;
	assign row_end_out   = row_end_q;
	assign run_final     = final_q;

endmodule

[rtl/box_blur_row_stream.sv]
// Top level of the horizontal box blur: sequencer, pixel window, four channel lanes, merge.
// Depends on bbr_pkg, bbr_window, bbr_lane, bbr_merge.
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+-----
//  in      | in_valid, in_stall, pixel_in, row_end_in         | in
//  out     | out_valid, out_stall, blurred_pixel, row_end_out,| out
//          | run_final                                        |
//  cfg     | cfg_we, cfg_wdata (blur radius)                  | in
//
// An item that yields no result leaves the sequencer idle. Each result reads its 2r+1 taps
// through the single read port of the window memory, then takes one drain, one multiply and
// one push step. A row-end item yields min(count, r)+1 results.
// Items are taken one at a time; a held result does not block the next item.
// Output stall holds the push cycle. Reset sets r = 1; the window needs no clearing.
module box_blur_row_stream (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bbr_pkg::PIX_W-1:0]    pixel_in,
	input  logic                         row_end_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bbr_pkg::PIX_W-1:0]    blurred_pixel,
	output logic                         row_end_out,
	output logic                         run_final,
	input  logic                         cfg_we,
	input  logic [bbr_pkg::RADIUS_W-1:0] cfg_wdata
);
	import bbr_pkg::*;

	bbr_state_t state_q, state_d;

	logic [RADIUS_W-1:0] radius_q;
	logic [RECIP_W-1:0]  recip_q;
	logic [COUNT_W-1:0]  count_q;
	logic [COUNT_W-1:0]  item_k_q;
	logic                flush_q;
	logic [RADIUS_W-1:0] m_q;
	logic [COUNT_W-1:0]  t_q;
	logic                rd_valid_s1;

	logic                in_acc;
	logic                has_out;
	logic [RADIUS_W-1:0] m_first;
	logic                t_last;
	logic                more;
	logic                out_free;
	logic                rd_issue;
	logic signed [COUNT_W:0] o_raw;
	logic [COUNT_W-1:0]  o_clamp;
	logic [WIN_AW-1:0]   raddr;
	logic [WIN_AW-1:0]   newest;
	logic [PIX_W-1:0]    rdata;
	lane_ctl_t           lane_ctl;
	merge_ctl_t          merge_ctl;
	logic [NUM_LANES-1:0][CH_W-1:0] lane_res;

	// item decode
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign has_out  = row_end_in || (count_q >= COUNT_W'(radius_q));
	assign m_first  = (row_end_in && (count_q < COUNT_W'(radius_q))) ?
		count_q[RADIUS_W-1:0] : radius_q;
	assign t_last   = (t_q == {radius_q, 1'b0});
	assign more     = flush_q && (m_q != '0);

	// window offset of tap t for center m, clamped to the row
	assign o_raw = $signed({2'b00, m_q}) - $signed({2'b00, radius_q}) + $signed({1'b0, t_q});

	always_comb begin
		priority if (o_raw < 0) begin
			o_clamp = '0;
		end else if (o_raw[COUNT_W-1:0] > item_k_q) begin
			o_clamp = item_k_q;
		end else begin
			o_clamp = o_raw[COUNT_W-1:0];
		end
	end

	assign raddr = newest - o_clamp[WIN_AW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && has_out) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (t_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_MUL;
			ST_MUL:   state_d = ST_PUSH;
			ST_PUSH: begin
				if (out_free) state_d = more ? ST_RUN : ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		rd_issue            = (state_q == ST_RUN);
		lane_ctl.clear      = ((state_q == ST_IDLE) && in_acc && has_out) ||
			((state_q == ST_PUSH) && out_free && more);
		lane_ctl.acc_en     = rd_valid_s1;
		lane_ctl.mul_en     = (state_q == ST_MUL);
		merge_ctl.load      = (state_q == ST_PUSH) && out_free;
		merge_ctl.row_end   = flush_q && (m_q == '0);
		merge_ctl.run_final = !flush_q || (m_q == '0);
	end

	// state, config and item registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			radius_q    <= RADIUS_RESET;
			recip_q     <= RECIP_TAB[RADIUS_RESET];
			count_q     <= '0;
			item_k_q    <= '0;
			flush_q     <= 1'b0;
			m_q         <= '0;
			t_q         <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_issue;
			if (cfg_we) begin
				// new radius drops the partial row
				radius_q <= cfg_wdata;
				recip_q  <= RECIP_TAB[cfg_wdata];
				count_q  <= '0;
			end else if (in_acc) begin
				item_k_q <= count_q;
				flush_q  <= row_end_in;
				m_q      <= m_first;
				t_q      <= '0;
				if (row_end_in) begin
					count_q <= '0;
				end else if (count_q != COUNT_MAX) begin
					count_q <= count_q + COUNT_W'(1);
				end
			end else if (state_q == ST_RUN) begin
				t_q <= t_q + COUNT_W'(1);
			end else if ((state_q == ST_PUSH) && out_free && more) begin
				m_q <= m_q - RADIUS_W'(1);
				t_q <= '0;
			end
		end
	end

	bbr_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (in_acc),
		.wdata  (pixel_in),
		.raddr  (raddr),
		.rdata  (rdata),
		.newest (newest)
	);

	// one lane per channel
	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		bbr_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lane_ctl),
			.pix    (rdata[i*CH_W +: CH_W]),
			.recip  (recip_q),
			.res    (lane_res[i])
		);
	end

	bbr_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (merge_ctl),
		.lane_res      (lane_res),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.blurred_pixel (blurred_pixel),
		.row_end_out   (row_end_out),
		.run_final     (run_final),
		.free          (out_free)
	);

	// tap counter never runs past the last tap
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (t_q <= {radius_q, 1'b0}))
		else $error("tap counter beyond 2r");

	// reads stay within the pixels of the current row
	a_read_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (o_clamp <= item_k_q))
		else $error("window read outside current row");

	// accumulator is never cleared while a tap lands
	a_clear_vs_acc: assert property (@(posedge clk) disable iff (!arst_n)
		!(lane_ctl.clear && lane_ctl.acc_en))
		else $error("lane clear overlaps accumulate");

	// multiply only follows the drain cycle
	a_mul_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> ($past(state_q) == ST_DRAIN))
		else $error("multiply without drain");

	// a mid-row result is always centered r pixels back
	a_mid_center: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_PUSH) && !flush_q) |-> (m_q == radius_q))
		else $error("mid-row result off center");

endmodule
